[hw/rtl/overlapping_ones_template_counter_assert.svh]
// Assertion macros for the overlapping ones template counter RTL
`ifndef OVERLAPPING_ONES_TEMPLATE_COUNTER_ASSERT_SVH
`define OVERLAPPING_ONES_TEMPLATE_COUNTER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define OOTC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ootc assertion failed");

// Next-cycle implication, checked outside reset
`define OOTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ootc assertion failed");

`endif

[hw/rtl/ootc_pkg.sv]
// Types and constants for the overlapping ones template counter
package ootc_pkg;

    localparam int WIN_W      = 6;
    localparam int BLOCK_W    = 11;
    localparam int TOTAL_W    = 32;
    localparam int MATCH_W    = 11;
    localparam int KIND_W     = 2;
    localparam int BIN_IDX_W  = 3;
    localparam int NUM_BINS   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [KIND_W-1:0] KIND_BLOCK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DUMP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SHORT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 2'd2;

    localparam logic [WIN_W-1:0]   WINDOW_RESET  = 6'd9;
    localparam logic [BLOCK_W-1:0] BLOCK_RESET   = 11'd1032;
    localparam logic [TOTAL_W-1:0] MIN_LEN_RESET = 32'd1000000;

    localparam logic [MATCH_W-1:0]   MATCH_MAX  = 11'h7FF;
    localparam logic [BIN_IDX_W-1:0] LAST_BIN   = 3'd5;
    localparam logic [MATCH_W-1:0]   LOW_BINS_MAX = 11'd4;

    // One queue entry: what one accepted bit leaves for the back end
    typedef struct packed {
        logic               has_block;
        logic [MATCH_W-1:0] hit_count;
        logic               has_end;
        logic               short_stream;
    } ootc_entry_t;

endpackage

[hw/rtl/ootc_front.sv]
// Front end: accepts stream bits, tracks runs and block matches, queues events
module ootc_front import ootc_pkg::*; #(
    parameter int MAX_WINDOW = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_bit_value,
    input  logic               s_end_of_stream,
    input  logic [WIN_W-1:0]   window_length,
    input  logic [BLOCK_W-1:0] block_length,
    input  logic [TOTAL_W-1:0] min_length,
    input  logic               queue_full,
    output logic               push,
    output ootc_entry_t        push_entry
);

    localparam int RUN_W = $clog2(MAX_WINDOW + 1);

    logic [RUN_W-1:0]   run_reg, run_next;
    logic [BLOCK_W-1:0] pos_reg, pos_next;
    logic [MATCH_W-1:0] matches_reg, matches_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic [RUN_W-1:0]   win;
    logic [RUN_W-1:0]   run_upd;
    logic [MATCH_W-1:0] matches_upd;
    logic [BLOCK_W-1:0] pos_inc;
    logic [TOTAL_W-1:0] total_inc;
    logic               block_end;
    logic               accept;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    // Clamp the template length into 1..MAX_WINDOW
    always_comb begin
        if (window_length == '0) begin
            win = RUN_W'(1);
        end else if (32'(window_length) > MAX_WINDOW) begin
            win = RUN_W'(MAX_WINDOW);
        end else begin
            win = RUN_W'(window_length);
        end
    end

    always_comb begin
        if (s_bit_value) begin
            run_upd = (run_reg < win) ? run_reg + 1'b1 : run_reg;
        end else begin
            run_upd = '0;
        end
        if (s_bit_value && (run_upd >= win) && (matches_reg != MATCH_MAX)) begin
            matches_upd = matches_reg + 1'b1;
        end else begin
            matches_upd = matches_reg;
        end
        pos_inc   = pos_reg + 1'b1;
        block_end = (pos_inc == block_length);
        total_inc = (&total_reg) ? total_reg : total_reg + 1'b1;
    end

    always_comb begin
        run_next     = run_reg;
        pos_next     = pos_reg;
        matches_next = matches_reg;
        total_next   = total_reg;
        if (accept) begin
            if (s_end_of_stream) begin
                run_next     = '0;
                pos_next     = '0;
                matches_next = '0;
                total_next   = '0;
            end else if (block_end) begin
                run_next     = '0;
                pos_next     = '0;
                matches_next = '0;
                total_next   = total_inc;
            end else begin
                run_next     = run_upd;
                pos_next     = pos_inc;
                matches_next = matches_upd;
                total_next   = total_inc;
            end
        end
    end

    assign push                    = accept && (block_end || s_end_of_stream);
    assign push_entry.has_block    = block_end;
    assign push_entry.hit_count    = matches_upd;
    assign push_entry.has_end      = s_end_of_stream;
    assign push_entry.short_stream = (total_inc < min_length);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= '0;
            pos_reg     <= '0;
            matches_reg <= '0;
            total_reg   <= '0;
        end else begin
            run_reg     <= run_next;
            pos_reg     <= pos_next;
            matches_reg <= matches_next;
            total_reg   <= total_next;
        end
    end

endmodule

[hw/rtl/ootc_fifo.sv]
// Short event queue between the front end and the back end
module ootc_fifo import ootc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  ootc_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output ootc_entry_t head_entry
);

    ootc_entry_t         mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full       = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/ootc_back.sv]
// Back end: bins block results, expands stream ends into dumps, drives the output register
`include "overlapping_ones_template_counter_assert.svh"

module ootc_back import ootc_pkg::*; #(
    parameter int BIN_COUNT_WIDTH = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       head_valid,
    input  ootc_entry_t                head_entry,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [KIND_W-1:0]          m_kind,
    output logic [MATCH_W-1:0]         m_block_matches,
    output logic [BIN_IDX_W-1:0]       m_bin_index,
    output logic [BIN_COUNT_WIDTH-1:0] m_bin_count,
    output logic                       m_last
);

    logic [BIN_COUNT_WIDTH-1:0] bins_reg [NUM_BINS];
    logic [BIN_COUNT_WIDTH-1:0] bins_next [NUM_BINS];
    logic                       blk_done_reg, blk_done_next;
    logic [BIN_IDX_W-1:0]       dump_idx_reg, dump_idx_next;

    logic                       m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]          m_kind_reg;
    logic [MATCH_W-1:0]         m_matches_reg;
    logic [BIN_IDX_W-1:0]       m_bin_index_reg;
    logic [BIN_COUNT_WIDTH-1:0] m_bin_count_reg;
    logic                       m_last_reg;

    logic                       out_free;
    logic                       fire;
    logic                       emit_block;
    logic                       is_final;
    logic [BIN_IDX_W-1:0]       blk_bin;
    logic [KIND_W-1:0]          res_kind;
    logic [MATCH_W-1:0]         res_matches;
    logic [BIN_IDX_W-1:0]       res_bin_index;
    logic [BIN_COUNT_WIDTH-1:0] res_bin_count;
    logic                       res_last;

    logic                       head_dump;
    logic                       head_block_end;
    logic                       rewound;

    assign out_free   = !m_valid_reg || m_ready;
    assign fire       = head_valid && out_free;
    assign emit_block = head_entry.has_block && !blk_done_reg;
    assign blk_bin    = (head_entry.hit_count <= LOW_BINS_MAX) ?
                        head_entry.hit_count[BIN_IDX_W-1:0] : LAST_BIN;
    assign pop        = fire && is_final;

    // Pick the result for the current step of the head transaction
    always_comb begin
        res_kind      = KIND_BLOCK;
        res_matches   = '0;
        res_bin_index = '0;
        res_bin_count = '0;
        res_last      = 1'b0;
        is_final      = 1'b0;
        if (emit_block) begin
            res_matches   = head_entry.hit_count;
            res_bin_index = blk_bin;
            is_final      = !head_entry.has_end;
        end else if (head_entry.short_stream) begin
            res_kind = KIND_SHORT;
            res_last = 1'b1;
            is_final = 1'b1;
        end else begin
            res_kind      = KIND_DUMP;
            res_bin_index = dump_idx_reg;
            res_bin_count = bins_reg[dump_idx_reg];
            res_last      = (dump_idx_reg == LAST_BIN);
            is_final      = (dump_idx_reg == LAST_BIN);
        end
    end

    always_comb begin
        blk_done_next = blk_done_reg;
        dump_idx_next = dump_idx_reg;
        if (fire) begin
            if (is_final) begin
                blk_done_next = 1'b0;
                dump_idx_next = '0;
            end else if (emit_block) begin
                blk_done_next = 1'b1;
            end else begin
                dump_idx_next = dump_idx_reg + 1'b1;
            end
        end
    end

    // Saturating bin update; wipe all bins once a stream end is delivered
    always_comb begin
        for (int i = 0; i < NUM_BINS; i++) begin
            bins_next[i] = bins_reg[i];
            if (fire && emit_block && (blk_bin == BIN_IDX_W'(i)) && !(&bins_reg[i])) begin
                bins_next[i] = bins_reg[i] + 1'b1;
            end
            if (fire && is_final && head_entry.has_end) begin
                bins_next[i] = '0;
            end
        end
    end

    assign m_valid_next = fire ? 1'b1 : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_done_reg <= 1'b0;
            dump_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_BINS; i++) begin
                bins_reg[i] <= '0;
            end
        end else begin
            blk_done_reg <= blk_done_next;
            dump_idx_reg <= dump_idx_next;
            m_valid_reg  <= m_valid_next;
            for (int i = 0; i < NUM_BINS; i++) begin
                bins_reg[i] <= bins_next[i];
            end
        end
    end

    // Load the output register whenever it is free and a head entry is waiting
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_kind_reg      <= res_kind;
            m_matches_reg   <= res_matches;
            m_bin_index_reg <= res_bin_index;
            m_bin_count_reg <= res_bin_count;
            m_last_reg      <= res_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_block_matches = m_matches_reg;
    assign m_bin_index     = m_bin_index_reg;
    assign m_bin_count     = m_bin_count_reg;
    assign m_last          = m_last_reg;

    assign head_dump      = head_valid && head_entry.has_end && !head_entry.short_stream;
    assign head_block_end = head_valid && head_entry.has_block && head_entry.has_end;
    assign rewound        = !blk_done_reg && (dump_idx_reg == '0);

    `OOTC_ASSERT_NOW(a_dump_needs_end, aclk, aresetn, dump_idx_reg != '0, head_dump)
    `OOTC_ASSERT_NOW(a_blk_done_needs_block, aclk, aresetn, blk_done_reg, head_block_end)
    `OOTC_ASSERT_NEXT(a_final_rewinds, aclk, aresetn, pop, rewound)
    `OOTC_ASSERT_NEXT(a_fire_shows_result, aclk, aresetn, fire, m_valid)

endmodule

[hw/rtl/overlapping_ones_template_counter.sv]
// Top level of the overlapping ones template counter: config registers and datapath
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_bit_value, s_end_of_stream
//   m_        out        m_valid / m_ready  m_kind, m_block_matches, m_bin_index,
//                                           m_bin_count, m_last
//   cfg_      in         cfg_we             cfg_index, cfg_data
//
// One bit is taken per cycle while the queue is not full; the front end's run, position
// and match counters are registers, and a result passes through the event queue into the
// output register. A non-short stream end makes the back end emit six dump transactions,
// one per cycle unless m_ stalls; the four-entry event queue keeps bits flowing meanwhile.
// Reset (aresetn low at a clock edge) clears all counters, bins and the queue and
// loads the register defaults; no clearing pass is needed.
// A stalled m_ side holds its result; s_ready drops only when the queue is full.
module overlapping_ones_template_counter import ootc_pkg::*; #(
    parameter int BIN_COUNT_WIDTH = 24,
    parameter int MAX_WINDOW      = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_bit_value,
    input  logic                       s_end_of_stream,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [KIND_W-1:0]          m_kind,
    output logic [MATCH_W-1:0]         m_block_matches,
    output logic [BIN_IDX_W-1:0]       m_bin_index,
    output logic [BIN_COUNT_WIDTH-1:0] m_bin_count,
    output logic                       m_last,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    logic [WIN_W-1:0]   window_length_reg;
    logic [BLOCK_W-1:0] block_length_reg;
    logic [TOTAL_W-1:0] min_length_reg;

    logic        queue_full;
    logic        push;
    ootc_entry_t push_entry;
    logic        pop;
    logic        head_valid;
    ootc_entry_t head_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WINDOW_RESET;
            block_length_reg  <= BLOCK_RESET;
            min_length_reg    <= MIN_LEN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data[WIN_W-1:0];
                REG_BLOCK_LENGTH:  block_length_reg  <= cfg_data[BLOCK_W-1:0];
                REG_MIN_LENGTH:    min_length_reg    <= cfg_data[TOTAL_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    ootc_front #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_bit_value     (s_bit_value),
        .s_end_of_stream (s_end_of_stream),
        .window_length   (window_length_reg),
        .block_length    (block_length_reg),
        .min_length      (min_length_reg),
        .queue_full      (queue_full),
        .push            (push),
        .push_entry      (push_entry)
    );

    ootc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    ootc_back #(
        .BIN_COUNT_WIDTH(BIN_COUNT_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_entry      (head_entry),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_block_matches (m_block_matches),
        .m_bin_index     (m_bin_index),
        .m_bin_count     (m_bin_count),
        .m_last          (m_last)
    );

endmodule
